### sv/thread_wait_queue_top_defines.svh
// Assertion macros shared by the thread wait queue RTL.
// Depends on: nothing; users provide clk and arst_n in scope.
`ifndef THREAD_WAIT_QUEUE_TOP_DEFINES_SVH
`define THREAD_WAIT_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TWQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TWQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/twq_pkg.sv
// Types, codes and microcode ROM of the thread wait queue.
// Depends on: nothing.
package twq_pkg;

	localparam int MAX_THREADS_DEF = 64;
	localparam int TID_W = 6;
	localparam int UPC_W = 5;

	typedef logic [UPC_W-1:0] pc_t;

	typedef enum logic [1:0] {
		REQ_ENQ,
		REQ_CANCEL,
		REQ_WAKE_ONE,
		REQ_WAKE_ALL
	} req_t;

	typedef enum logic [2:0] {
		ST_QUEUED,
		ST_WOKEN,
		ST_TIMEOUT,
		ST_NOT_QUEUED,
		ST_EMPTY,
		ST_DUPLICATE
	} status_t;

	typedef struct packed {
		req_t             req_type;
		logic [TID_W-1:0] thread_id;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [TID_W-1:0] woken_thread;
		logic             last;
	} result_t;

	// jump conditions
	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_EQ,
		J_FULL,
		J_MISS,
		J_NOT_LAST,
		J_DISPATCH
	} jmp_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_TAIL,
		WR_SHIFT
	} wr_t;

	typedef enum logic [1:0] {
		IDX_KEEP,
		IDX_CLR,
		IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef enum logic [1:0] {
		ID_REQ,
		ID_SLOT,
		ID_ZERO
	} id_sel_t;

	typedef struct packed {
		jmp_t    jmp;
		pc_t     target;
		logic    rd;
		wr_t     wr;
		idx_op_t idx;
		cnt_op_t cnt;
		logic    emit;
		status_t st;
		id_sel_t ids;
		logic    last_one;
		logic    last_chk;
	} ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic eq;    // index reached count
		logic full;
		logic hit;   // slot read back matches request id
		logic last;  // index is the final entry
		logic busy;  // result register occupied
	} flags_t;

	typedef struct packed {
		ctl_t word;
		logic adv;
		logic accept;
	} cmd_t;

	// program addresses
	localparam pc_t PC_IDLE = 5'd0;
	localparam pc_t PC_E0   = 5'd1;
	localparam pc_t PC_E1   = 5'd2;
	localparam pc_t PC_E2   = 5'd3;
	localparam pc_t PC_E3   = 5'd4;
	localparam pc_t PC_E4   = 5'd5;
	localparam pc_t PC_E5   = 5'd6;
	localparam pc_t PC_C0   = 5'd7;
	localparam pc_t PC_C1   = 5'd8;
	localparam pc_t PC_C2   = 5'd9;
	localparam pc_t PC_C3   = 5'd10;
	localparam pc_t PC_C4   = 5'd11;
	localparam pc_t PC_C5   = 5'd12;
	localparam pc_t PC_W0   = 5'd13;
	localparam pc_t PC_W1   = 5'd14;
	localparam pc_t PC_W2   = 5'd15;
	localparam pc_t PC_W3   = 5'd16;
	localparam pc_t PC_W4   = 5'd17;
	localparam pc_t PC_W5   = 5'd18;
	localparam pc_t PC_A0   = 5'd19;
	localparam pc_t PC_A1   = 5'd20;
	localparam pc_t PC_A2   = 5'd21;
	localparam pc_t PC_A3   = 5'd22;

	function automatic pc_t entry_pc(req_t r);
		pc_t pc;
		case (r)
			REQ_ENQ:      pc = PC_E0;
			REQ_CANCEL:   pc = PC_C0;
			REQ_WAKE_ONE: pc = PC_W0;
			REQ_WAKE_ALL: pc = PC_A0;
			default:      pc = PC_IDLE;
		endcase
		return pc;
	endfunction

	function automatic ctl_t rom_word(pc_t pc);
		ctl_t w;
		w = '{jmp: J_NEXT, target: PC_IDLE, rd: 1'b0, wr: WR_NONE, idx: IDX_KEEP,
			cnt: CNT_KEEP, emit: 1'b0, st: ST_QUEUED, ids: ID_REQ,
			last_one: 1'b0, last_chk: 1'b0};
		case (pc)
			PC_IDLE: begin
				w.jmp = J_DISPATCH; w.idx = IDX_CLR;
			end
			// enqueue: duplicate search, then full check
			PC_E0: begin
				w.jmp = J_EQ; w.target = PC_E3; w.rd = 1'b1;
			end
			PC_E1: begin
				w.jmp = J_MISS; w.target = PC_E0; w.idx = IDX_INC;
			end
			PC_E2: begin
				w.jmp = J_ALWAYS; w.emit = 1'b1; w.st = ST_DUPLICATE; w.last_one = 1'b1;
			end
			PC_E3: begin
				w.jmp = J_FULL; w.target = PC_E5;
			end
			PC_E4: begin
				w.jmp = J_ALWAYS; w.wr = WR_TAIL; w.cnt = CNT_INC;
				w.emit = 1'b1; w.st = ST_QUEUED; w.last_one = 1'b1;
			end
			PC_E5: begin
				w.jmp = J_ALWAYS; w.emit = 1'b1; w.st = ST_NOT_QUEUED; w.last_one = 1'b1;
			end
			// cancel: search, then close the gap
			PC_C0: begin
				w.jmp = J_EQ; w.target = PC_C5; w.rd = 1'b1;
			end
			PC_C1: begin
				w.jmp = J_MISS; w.target = PC_C0; w.idx = IDX_INC;
			end
			PC_C2: begin
				w.jmp = J_EQ; w.target = PC_C4; w.rd = 1'b1;
			end
			PC_C3: begin
				w.jmp = J_ALWAYS; w.target = PC_C2; w.wr = WR_SHIFT; w.idx = IDX_INC;
			end
			PC_C4: begin
				w.jmp = J_ALWAYS; w.cnt = CNT_DEC;
				w.emit = 1'b1; w.st = ST_TIMEOUT; w.last_one = 1'b1;
			end
			PC_C5: begin
				w.jmp = J_ALWAYS; w.emit = 1'b1; w.st = ST_NOT_QUEUED; w.last_one = 1'b1;
			end
			// wake one: pop head, shift the rest up
			PC_W0: begin
				w.jmp = J_EQ; w.target = PC_W5; w.rd = 1'b1;
			end
			PC_W1: begin
				w.idx = IDX_INC; w.emit = 1'b1; w.st = ST_WOKEN;
				w.ids = ID_SLOT; w.last_one = 1'b1;
			end
			PC_W2: begin
				w.jmp = J_EQ; w.target = PC_W4; w.rd = 1'b1;
			end
			PC_W3: begin
				w.jmp = J_ALWAYS; w.target = PC_W2; w.wr = WR_SHIFT; w.idx = IDX_INC;
			end
			PC_W4: begin
				w.jmp = J_ALWAYS; w.cnt = CNT_DEC;
			end
			PC_W5: begin
				w.jmp = J_ALWAYS; w.emit = 1'b1; w.st = ST_EMPTY;
				w.ids = ID_ZERO; w.last_one = 1'b1;
			end
			// wake all: drain in order
			PC_A0: begin
				w.jmp = J_EQ; w.target = PC_A3; w.rd = 1'b1;
			end
			PC_A1: begin
				w.jmp = J_NOT_LAST; w.target = PC_A0; w.idx = IDX_INC;
				w.emit = 1'b1; w.st = ST_WOKEN; w.ids = ID_SLOT; w.last_chk = 1'b1;
			end
			PC_A2: begin
				w.jmp = J_ALWAYS; w.cnt = CNT_CLR;
			end
			PC_A3: begin
				w.jmp = J_ALWAYS; w.emit = 1'b1; w.st = ST_EMPTY;
				w.ids = ID_ZERO; w.last_one = 1'b1;
			end
			default: begin
				w.jmp = J_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

### sv/thread_wait_queue_top.sv
// Top level of the thread wait queue: sequencer plus datapath.
// Depends on: twq_pkg, twq_seq, twq_dp, thread_wait_queue_top_defines.svh.
`include "thread_wait_queue_top_defines.svh"

// FIFO wait queue of thread ids, head at slot 0, with cancel by name.
// One request item is taken at a time; request_stall stays high from
// acceptance until the microprogram is back at its idle step, which for
// wake one and wake all is after the final result has been emitted (a
// finished result may still sit in the output register while the next
// request is taken). Cost is set by the slot memory, which has one read
// port and registered read data: every slot visit is two microcode steps.
// Enqueue walks every entry for a new thread or a full queue, and stops
// at a duplicate found at position p (head is 0). Cancel walks every
// entry, found or not. Wake one walks every entry. Wake all gives one
// result item per thread, the last with last=1. An empty wake gives a
// single ST_EMPTY result. An emit step waits while the result register
// is full and stalled. No clearing pass after reset: slots are only read
// below the entry count.
module thread_wait_queue_top import twq_pkg::*; #(
	parameter int MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_stall,
	input  request_t request,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	cmd_t   cmd;
	flags_t flags;
	logic   busy;

	// sequencer: program counter over the ROM, dispatch on request type
	twq_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.req_type     (request.req_type),
		.flags        (flags),
		.result_stall (result_stall),
		.cmd          (cmd),
		.busy         (busy)
	);

	// datapath: slots, index/count, result register
	twq_dp #(
		.MAX_THREADS(MAX_THREADS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.thread_id   (request.thread_id),
		.result_stall(result_stall),
		.flags       (flags),
		.result_valid(result_valid),
		.result      (result)
	);

	// new requests only while the program sits at idle
	assign request_stall = busy;

	// tail write only happens with room left
	`TWQ_ASSERT_IMP(a_tail_not_full, cmd.word.wr == WR_TAIL && cmd.adv, !flags.full, "tail write into full queue")
	// an accepted item keeps the sequencer busy next cycle
	`TWQ_ASSERT_NXT(a_busy_after_accept, request_valid && !request_stall, request_stall, "accepted item did not start program")
	// a non-final drain result means the drain is still running
	`TWQ_ASSERT_IMP(a_drain_busy, result_valid && !result.last, request_stall, "partial drain result while idle")

endmodule

### sv/twq_seq.sv
// Microcode sequencer: step counter, ROM lookup, jump and stall logic.
// Depends on: twq_pkg.
module twq_seq import twq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   request_valid,
	input  req_t   req_type,
	input  flags_t flags,
	input  logic   result_stall,
	output cmd_t   cmd,
	output logic   busy
);

	pc_t  upc_q;
	pc_t  upc_d;
	ctl_t w;
	logic hold;
	logic take;
	logic accept;

	always_comb begin
		w      = rom_word(upc_q);
		busy   = (upc_q != PC_IDLE);
		accept = request_valid && !busy;
		// an emit step waits while the result register is full and stalled
		hold   = w.emit && flags.busy && result_stall;
		case (w.jmp)
			J_ALWAYS:   take = 1'b1;
			J_EQ:       take = flags.eq;
			J_FULL:     take = flags.full;
			J_MISS:     take = !flags.hit;
			J_NOT_LAST: take = !flags.last;
			J_DISPATCH: take = accept;
			default:    take = 1'b0;
		endcase
		if (hold) begin
			upc_d = upc_q;
		end else if (w.jmp == J_DISPATCH) begin
			upc_d = take ? entry_pc(req_type) : upc_q;
		end else begin
			upc_d = take ? w.target : upc_q + pc_t'(1);
		end
		cmd = '{word: w, adv: !hold, accept: accept};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= PC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

### sv/twq_dp.sv
// Datapath: slot memory, index and count registers, result register.
// Depends on: twq_pkg.
module twq_dp import twq_pkg::*; #(
	parameter int MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [TID_W-1:0] thread_id,
	input  logic             result_stall,
	output flags_t           flags,
	output logic             result_valid,
	output result_t          result
);

	localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = $clog2(MAX_THREADS + 1);

	logic [TID_W-1:0] slots_q [MAX_THREADS];
	logic [TID_W-1:0] rd_q;
	logic [TID_W-1:0] id_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_m1;
	result_t          result_q;
	logic             rvalid_q;

	logic             rd_en;
	logic             wr_en;
	logic             emit_en;
	logic [IW-1:0]    waddr;
	logic [TID_W-1:0] wdata;
	logic [TID_W-1:0] res_id;

	always_comb begin
		flags.eq   = (idx_q == cnt_q);
		flags.full = (cnt_q == CW'(MAX_THREADS));
		flags.hit  = (rd_q == id_q);
		flags.last = ((idx_q + CW'(1)) == cnt_q);
		flags.busy = rvalid_q;

		rd_en   = cmd.word.rd && cmd.adv && !flags.eq;
		wr_en   = (cmd.word.wr != WR_NONE) && cmd.adv;
		emit_en = cmd.word.emit && cmd.adv;
		idx_m1  = idx_q - CW'(1);

		if (cmd.word.wr == WR_SHIFT) begin
			waddr = idx_m1[IW-1:0];
			wdata = rd_q;
		end else begin
			waddr = cnt_q[IW-1:0];
			wdata = id_q;
		end

		case (cmd.word.ids)
			ID_SLOT: res_id = rd_q;
			ID_ZERO: res_id = '0;
			default: res_id = id_q;
		endcase
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= slots_q[idx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q <= thread_id;
		end
		if (emit_en) begin
			result_q <= '{status: cmd.word.st, woken_thread: res_id,
				last: cmd.word.last_one | (cmd.word.last_chk & flags.last)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.adv) begin
				case (cmd.word.idx)
					IDX_CLR: idx_q <= '0;
					IDX_INC: idx_q <= idx_q + CW'(1);
					default: idx_q <= idx_q;
				endcase
				case (cmd.word.cnt)
					CNT_INC: cnt_q <= cnt_q + CW'(1);
					CNT_DEC: cnt_q <= cnt_q - CW'(1);
					CNT_CLR: cnt_q <= '0;
					default: cnt_q <= cnt_q;
				endcase
			end
			if (emit_en) begin
				rvalid_q <= 1'b1;
			end else if (!result_stall) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	assign result_valid = rvalid_q;
	assign result       = result_q;

endmodule
